>>> src/sha512fx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed 32-byte SHA-512 core.
// Holds the round constant table, initial hash values and controller commands.
package sha512fx_pkg;

    localparam int WORD_W     = 64;
    localparam int MSG_WORDS  = 4;
    localparam int SCHED_LEN  = 16;
    localparam int HASH_WORDS = 8;
    localparam int ROUNDS     = 80;
    localparam int ROUND_W    = $clog2(ROUNDS);

    localparam logic [WORD_W-1:0] PAD_MARK = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] LEN_BITS = WORD_W'(MSG_WORDS * 64);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ROUND_W-1:0] round_t;

    // Controller to datapath commands
    typedef struct packed {
        logic   load;      // capture message, pad, start from initial hash
        logic   step;      // run one compression round
        logic   load_out;  // add back into initial hash, fill output register
        round_t round;     // current round index
    } ctrl_cmd_t;

    localparam word_t INIT_H [HASH_WORDS] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    function automatic word_t round_k(input round_t idx);
        word_t k;
        case (idx)
            7'd0:  k = 64'h428A2F98D728AE22;
            7'd1:  k = 64'h7137449123EF65CD;
            7'd2:  k = 64'hB5C0FBCFEC4D3B2F;
            7'd3:  k = 64'hE9B5DBA58189DBBC;
            7'd4:  k = 64'h3956C25BF348B538;
            7'd5:  k = 64'h59F111F1B605D019;
            7'd6:  k = 64'h923F82A4AF194F9B;
            7'd7:  k = 64'hAB1C5ED5DA6D8118;
            7'd8:  k = 64'hD807AA98A3030242;
            7'd9:  k = 64'h12835B0145706FBE;
            7'd10: k = 64'h243185BE4EE4B28C;
            7'd11: k = 64'h550C7DC3D5FFB4E2;
            7'd12: k = 64'h72BE5D74F27B896F;
            7'd13: k = 64'h80DEB1FE3B1696B1;
            7'd14: k = 64'h9BDC06A725C71235;
            7'd15: k = 64'hC19BF174CF692694;
            7'd16: k = 64'hE49B69C19EF14AD2;
            7'd17: k = 64'hEFBE4786384F25E3;
            7'd18: k = 64'h0FC19DC68B8CD5B5;
            7'd19: k = 64'h240CA1CC77AC9C65;
            7'd20: k = 64'h2DE92C6F592B0275;
            7'd21: k = 64'h4A7484AA6EA6E483;
            7'd22: k = 64'h5CB0A9DCBD41FBD4;
            7'd23: k = 64'h76F988DA831153B5;
            7'd24: k = 64'h983E5152EE66DFAB;
            7'd25: k = 64'hA831C66D2DB43210;
            7'd26: k = 64'hB00327C898FB213F;
            7'd27: k = 64'hBF597FC7BEEF0EE4;
            7'd28: k = 64'hC6E00BF33DA88FC2;
            7'd29: k = 64'hD5A79147930AA725;
            7'd30: k = 64'h06CA6351E003826F;
            7'd31: k = 64'h142929670A0E6E70;
            7'd32: k = 64'h27B70A8546D22FFC;
            7'd33: k = 64'h2E1B21385C26C926;
            7'd34: k = 64'h4D2C6DFC5AC42AED;
            7'd35: k = 64'h53380D139D95B3DF;
            7'd36: k = 64'h650A73548BAF63DE;
            7'd37: k = 64'h766A0ABB3C77B2A8;
            7'd38: k = 64'h81C2C92E47EDAEE6;
            7'd39: k = 64'h92722C851482353B;
            7'd40: k = 64'hA2BFE8A14CF10364;
            7'd41: k = 64'hA81A664BBC423001;
            7'd42: k = 64'hC24B8B70D0F89791;
            7'd43: k = 64'hC76C51A30654BE30;
            7'd44: k = 64'hD192E819D6EF5218;
            7'd45: k = 64'hD69906245565A910;
            7'd46: k = 64'hF40E35855771202A;
            7'd47: k = 64'h106AA07032BBD1B8;
            7'd48: k = 64'h19A4C116B8D2D0C8;
            7'd49: k = 64'h1E376C085141AB53;
            7'd50: k = 64'h2748774CDF8EEB99;
            7'd51: k = 64'h34B0BCB5E19B48A8;
            7'd52: k = 64'h391C0CB3C5C95A63;
            7'd53: k = 64'h4ED8AA4AE3418ACB;
            7'd54: k = 64'h5B9CCA4F7763E373;
            7'd55: k = 64'h682E6FF3D6B2B8A3;
            7'd56: k = 64'h748F82EE5DEFB2FC;
            7'd57: k = 64'h78A5636F43172F60;
            7'd58: k = 64'h84C87814A1F0AB72;
            7'd59: k = 64'h8CC702081A6439EC;
            7'd60: k = 64'h90BEFFFA23631E28;
            7'd61: k = 64'hA4506CEBDE82BDE9;
            7'd62: k = 64'hBEF9A3F7B2C67915;
            7'd63: k = 64'hC67178F2E372532B;
            7'd64: k = 64'hCA273ECEEA26619C;
            7'd65: k = 64'hD186B8C721C0C207;
            7'd66: k = 64'hEADA7DD6CDE0EB1E;
            7'd67: k = 64'hF57D4F7FEE6ED178;
            7'd68: k = 64'h06F067AA72176FBA;
            7'd69: k = 64'h0A637DC5A2C898A6;
            7'd70: k = 64'h113F9804BEF90DAE;
            7'd71: k = 64'h1B710B35131C471B;
            7'd72: k = 64'h28DB77F523047D84;
            7'd73: k = 64'h32CAAB7B40C72493;
            7'd74: k = 64'h3C9EBE0A15C9BEBC;
            7'd75: k = 64'h431D67C49C100D4C;
            7'd76: k = 64'h4CC5D4BECB3E42B6;
            7'd77: k = 64'h597F299CFC657E2A;
            7'd78: k = 64'h5FCB6FAB3AD6FAEC;
            7'd79: k = 64'h6C44198C4A475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

>>> src/sha512fx_ctrl.sv
`timescale 1ns / 1ps
// Controller for the fixed 32-byte SHA-512 core: input and output handshakes,
// round counter and datapath commands. Depends on sha512fx_pkg.
module sha512fx_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sha512fx_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    state_t                state_reg, state_next;
    sha512fx_pkg::round_t  round_reg, round_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.round      = round_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (round_reg == sha512fx_pkg::round_t'(sha512fx_pkg::ROUNDS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                // hold the finished state until the output register frees up
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/sha512fx_dp.sv
`timescale 1ns / 1ps
// Datapath for the fixed 32-byte SHA-512 core: message schedule window,
// shared round unit, final add and output register. Depends on sha512fx_pkg.
module sha512fx_dp (
    input  logic                    clk,
    input  sha512fx_pkg::ctrl_cmd_t cmd,
    input  sha512fx_pkg::word_t     msg_word0,
    input  sha512fx_pkg::word_t     msg_word1,
    input  sha512fx_pkg::word_t     msg_word2,
    input  sha512fx_pkg::word_t     msg_word3,
    output sha512fx_pkg::word_t     digest [sha512fx_pkg::HASH_WORDS]
);

    sha512fx_pkg::word_t w_reg [sha512fx_pkg::SCHED_LEN];
    sha512fx_pkg::word_t w_next [sha512fx_pkg::SCHED_LEN];
    sha512fx_pkg::word_t v_reg [sha512fx_pkg::HASH_WORDS];
    sha512fx_pkg::word_t v_next [sha512fx_pkg::HASH_WORDS];
    sha512fx_pkg::word_t dig_reg [sha512fx_pkg::HASH_WORDS];

    sha512fx_pkg::word_t s0, s1, w_new;
    sha512fx_pkg::word_t big0, big1, ch, maj, t1, t2;

    // Window holds w[t..t+15]; the word shifted in is w[t+16]
    always_comb
    begin
        s0 = sha512fx_pkg::rotr(w_reg[1], 1) ^ sha512fx_pkg::rotr(w_reg[1], 8)
           ^ (w_reg[1] >> 7);
        s1 = sha512fx_pkg::rotr(w_reg[14], 19) ^ sha512fx_pkg::rotr(w_reg[14], 61)
           ^ (w_reg[14] >> 6);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_comb
    begin
        big1 = sha512fx_pkg::rotr(v_reg[4], 14) ^ sha512fx_pkg::rotr(v_reg[4], 18)
             ^ sha512fx_pkg::rotr(v_reg[4], 41);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + sha512fx_pkg::round_k(cmd.round) + w_reg[0];
        big0 = sha512fx_pkg::rotr(v_reg[0], 28) ^ sha512fx_pkg::rotr(v_reg[0], 34)
             ^ sha512fx_pkg::rotr(v_reg[0], 39);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    always_comb
    begin
        w_next = w_reg;
        v_next = v_reg;
        if (cmd.load)
        begin
            // pad the 32-byte message into one block
            for (int i = 0; i < sha512fx_pkg::SCHED_LEN; i++)
            begin
                w_next[i] = '0;
            end
            w_next[0]  = msg_word0;
            w_next[1]  = msg_word1;
            w_next[2]  = msg_word2;
            w_next[3]  = msg_word3;
            w_next[4]  = sha512fx_pkg::PAD_MARK;
            w_next[15] = sha512fx_pkg::LEN_BITS;
            v_next     = sha512fx_pkg::INIT_H;
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < sha512fx_pkg::SCHED_LEN - 1; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[sha512fx_pkg::SCHED_LEN - 1] = w_new;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
        if (cmd.load_out)
        begin
            for (int i = 0; i < sha512fx_pkg::HASH_WORDS; i++)
            begin
                dig_reg[i] <= sha512fx_pkg::INIT_H[i] + v_reg[i];
            end
        end
    end

    assign digest = dig_reg;

endmodule

>>> src/sha512_fixed_32_byte_hash_core.sv
`timescale 1ns / 1ps
// SHA-512 of a fixed 32-byte message, one full digest per message.
// The padded block loads at the input transfer edge, then the rounds run on the
// shared round unit, and a final add fills the output register and sets out_valid.
// One message is hashed at a time: a new message is taken once the result sits in
// the output register, and the final add waits while an earlier digest is not taken.
// rst_n clears the controller and output valid.
module sha512_fixed_32_byte_hash_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sha512fx_pkg::word_t msg_word0,
    input  sha512fx_pkg::word_t msg_word1,
    input  sha512fx_pkg::word_t msg_word2,
    input  sha512fx_pkg::word_t msg_word3,
    output logic                out_valid,
    input  logic                out_ready,
    output sha512fx_pkg::word_t digest_word0,
    output sha512fx_pkg::word_t digest_word1,
    output sha512fx_pkg::word_t digest_word2,
    output sha512fx_pkg::word_t digest_word3,
    output sha512fx_pkg::word_t digest_word4,
    output sha512fx_pkg::word_t digest_word5,
    output sha512fx_pkg::word_t digest_word6,
    output sha512fx_pkg::word_t digest_word7
);

    sha512fx_pkg::ctrl_cmd_t cmd;
    sha512fx_pkg::word_t     digest [sha512fx_pkg::HASH_WORDS];

    sha512fx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sha512fx_dp u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .msg_word0 (msg_word0),
        .msg_word1 (msg_word1),
        .msg_word2 (msg_word2),
        .msg_word3 (msg_word3),
        .digest    (digest)
    );

    assign digest_word0 = digest[0];
    assign digest_word1 = digest[1];
    assign digest_word2 = digest[2];
    assign digest_word3 = digest[3];
    assign digest_word4 = digest[4];
    assign digest_word5 = digest[5];
    assign digest_word6 = digest[6];
    assign digest_word7 = digest[7];

`ifndef NO_ASSERTIONS
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && cmd.step && cmd.round == '0))
        else $error("round unit did not start after input transfer");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cmd.round < sha512fx_pkg::round_t'(sha512fx_pkg::ROUNDS)))
        else $error("round index out of range");

    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("output valid without final add");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("pending digest overwritten");
`endif

endmodule
